FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the queue RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// Types and fixed widths of the double-ended queue.
// ---------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_REAR  = 2'd0,
    FUNC_POP_FRONT  = 2'd1,
    FUNC_PUSH_FRONT = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } deq_func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } deq_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/double_ended_queue.sv
// ---------------------------------------------------------------------------
// double_ended_queue
// Circular double-ended queue held in a synchronous RAM, with push and pop
// at both the front and the rear.
//
//   Channel | Direction | tdata                          | tuser
//   in_     | slave     | data_in[31:0]                  | func[1:0]
//   out_    | master    | data_out[31:0], occupancy[36:32] | status[1:0]
//
// One transfer is taken per cycle while no result is stalled; its result appears the next cycle.
// Indices and count update at acceptance, the RAM write or read is issued in
// the same cycle, and popped data comes from the RAM read register.
// A stalled result holds the input off, so the read register stays put.
// Reset clears indices, count and the result valid flag; the RAM needs none.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // data_in[31:0]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // data_out[31:0], occupancy[36:32], zero
  output logic      [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_pop_r,   out_pop_nxt;
  deq_status_t       out_stat_r,  out_stat_nxt;
  logic [OCC_W-1:0]  out_occ_r,   out_occ_nxt;

  logic              in_fire;
  deq_func_t         func;
  logic              is_full, is_empty;
  logic              ram_we, ram_re;
  logic [IW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] rd_data;
  logic [CW+OCC_W-1:0] cnt_ext;
  logic              push_refused;
  logic              idx_zero;
  logic              out_stall;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == IW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] prev_slot(input logic [IW-1:0] i);
    return (i == '0) ? IW'(DEPTH - 1) : i - 1'b1;
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign func      = deq_func_t'(in_tuser);
  assign is_full   = (cnt_r == CW'(DEPTH));
  assign is_empty  = (cnt_r == '0);

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = '0;
    ram_raddr     = head_r;
    out_pop_nxt   = out_pop_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_pop_nxt   = 1'b0;
      out_stat_nxt  = STAT_DONE;
      unique case (func)
        FUNC_PUSH_REAR, FUNC_PUSH_FRONT: begin
          if (is_full) begin
            out_stat_nxt = STAT_FULL;
          end else begin
            if (is_empty) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              ram_waddr = '0;
            end else if (func == FUNC_PUSH_REAR) begin
              tail_nxt  = next_slot(tail_r);
              ram_waddr = tail_nxt;
            end else begin
              head_nxt  = prev_slot(head_r);
              ram_waddr = head_nxt;
            end
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        FUNC_POP_FRONT, FUNC_POP_REAR: begin
          if (is_empty) begin
            out_stat_nxt = STAT_EMPTY;
          end else begin
            ram_re      = 1'b1;
            out_pop_nxt = 1'b1;
            if (func == FUNC_POP_FRONT) begin
              ram_raddr = head_r;
              head_nxt  = next_slot(head_r);
            end else begin
              ram_raddr = tail_r;
              tail_nxt  = prev_slot(tail_r);
            end
            cnt_nxt = cnt_r - 1'b1;
            if (cnt_nxt == '0) begin
              head_nxt = '0;
              tail_nxt = '0;
            end
          end
        end
        default: begin
          out_stat_nxt = STAT_DONE;
        end
      endcase
    end
  end

  assign cnt_ext     = {{OCC_W{1'b0}}, cnt_nxt};
  assign out_occ_nxt = in_fire ? cnt_ext[OCC_W-1:0] : out_occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pop_r  <= out_pop_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, (out_pop_r ? rd_data : {DATA_W{1'b0}})};
  assign out_tuser  = out_stat_r;

  assign push_refused = in_fire && is_full &&
                        ((func == FUNC_PUSH_REAR) || (func == FUNC_PUSH_FRONT));
  assign idx_zero     = (head_r == '0) && (tail_r == '0);
  assign out_stall    = out_valid_r && !out_tready;

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CW'(DEPTH), "count exceeds depth")
  `ASSERT_ALWAYS(a_empty_idx, clk, rst_n, !is_empty || idx_zero, "indices set while empty")
  `ASSERT_NEXT(a_full_hold, clk, rst_n, push_refused, $stable(cnt_r), "refused push moved count")
  `ASSERT_NEXT(a_rd_hold, clk, rst_n, out_stall, $stable(rd_data), "read data moved in stall")

endmodule

`default_nettype wire

FILE: rtl/core/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: bench/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the double-ended queue
// Drives push and pop operations at both ends through the input stream and
// checks every result against a behavioural deque kept in the bench. It covers
// refused pops on an empty queue, refused pushes on a full queue, data
// extremes, long receiver hold-offs with input back-pressure, and random
// traffic with push- or pop-heavy phases under random idling on both sides.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 500000;

  typedef struct {
    logic [31:0]  data;
    deq_status_t  status;
    logic [4:0]   occ;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [31:0] slots [DEPTH];
  int unsigned front_slot;
  int unsigned rear_slot;
  int unsigned fill_count;

  deq_result_t owed_results[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          sender_gap_max = 19;
  int          rx_gap_max = 19;
  int          rx_hold_cycles = 0;

  double_ended_queue #(.DEPTH(DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic deq_result_t deque_apply(deq_func_t f, logic [31:0] value);
    deq_result_t r;
    r.data = '0;
    r.status = STAT_DONE;
    if (f == FUNC_PUSH_REAR || f == FUNC_PUSH_FRONT) begin
      if (fill_count >= DEPTH) begin
        r.status = STAT_FULL;
      end else begin
        if (fill_count == 0) begin
          front_slot = 0;
          rear_slot = 0;
        end else if (f == FUNC_PUSH_REAR) begin
          rear_slot = (rear_slot + 1) % DEPTH;
        end else begin
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
        end
        if (f == FUNC_PUSH_REAR) slots[rear_slot] = value;
        else slots[front_slot] = value;
        fill_count++;
      end
    end else if (fill_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      if (f == FUNC_POP_FRONT) begin
        r.data = slots[front_slot];
        front_slot = (front_slot + 1) % DEPTH;
      end else begin
        r.data = slots[rear_slot];
        rear_slot = (rear_slot + DEPTH - 1) % DEPTH;
      end
      fill_count--;
      if (fill_count == 0) begin
        front_slot = 0;
        rear_slot = 0;
      end
    end
    r.occ = 5'(fill_count);
    return r;
  endfunction

  // One transfer on the input side; the expectation is formed at acceptance.
  task automatic issue_op(deq_func_t f, logic [31:0] value);
    int gap;
    gap = $urandom_range(0, sender_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    owed_results.push_back(deque_apply(f, value));
  endtask

  task automatic drain_wait();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    issue_op(FUNC_POP_FRONT,  32'hDEAD_BEEF);
    issue_op(FUNC_POP_REAR,   32'hFFFF_FFFF);
    issue_op(FUNC_PUSH_FRONT, 32'h8000_0000);
    issue_op(FUNC_PUSH_REAR,  32'h7FFF_FFFF);
    issue_op(FUNC_PUSH_FRONT, 32'h0000_0000);
    issue_op(FUNC_PUSH_REAR,  32'hFFFF_FFFF);
    issue_op(FUNC_POP_FRONT,  32'h0000_0000);
    issue_op(FUNC_POP_REAR,   32'h5555_5555);
    issue_op(FUNC_POP_FRONT,  32'hAAAA_AAAA);
    issue_op(FUNC_POP_REAR,   32'h0000_0000);
    issue_op(FUNC_POP_REAR,   32'h0000_0000);
    issue_op(FUNC_PUSH_REAR,  32'h1234_5678);
    issue_op(FUNC_POP_FRONT,  32'h0000_0000);
    drain_wait();
  endtask

  // The receiver holds off for a long stretch while pushes keep coming, so
  // the block stalls its input; the queue then fills and refuses pushes.
  task automatic test_full_queue();
    rx_hold_cycles = 300;
    sender_gap_max = 0;
    for (int k = 0; k < 20; k++) begin
      issue_op(k[0] ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR, pick_value());
    end
    drain_wait();
    sender_gap_max = 19;
    for (int k = 0; k < 18; k++) begin
      issue_op(k[0] ? FUNC_POP_FRONT : FUNC_POP_REAR, pick_value());
    end
    drain_wait();
  endtask

  task automatic test_random_traffic();
    int push_pct;
    int gap_choice [3];
    deq_func_t f;
    gap_choice = '{0, 3, 19};
    for (int b = 0; b < 30; b++) begin
      case ($urandom_range(0, 2))
        0: push_pct = 15;
        1: push_pct = 50;
        default: push_pct = 85;
      endcase
      sender_gap_max = gap_choice[$urandom_range(0, 2)];
      rx_gap_max = gap_choice[$urandom_range(0, 2)];
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          f = $urandom_range(0, 1) ? FUNC_PUSH_FRONT : FUNC_PUSH_REAR;
        end else begin
          f = $urandom_range(0, 1) ? FUNC_POP_FRONT : FUNC_POP_REAR;
        end
        issue_op(f, pick_value());
      end
      if (b % 10 == 9) drain_wait();
    end
    drain_wait();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    front_slot = 0;
    rear_slot  = 0;
    fill_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_queue();
    test_random_traffic();
    while (owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      stall = $urandom_range(0, rx_gap_max);
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    deq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result transfer: data %h status %0d occupancy %0d",
                   out_tdata[31:0], out_tuser, out_tdata[36:32]);
        end
      end else begin
        want = owed_results.pop_front();
        if (out_tdata[31:0] !== want.data || out_tuser !== want.status ||
            out_tdata[36:32] !== want.occ) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: want data %h st %0d occ %0d, got data %h st %0d occ %0d",
                     want.data, want.status, want.occ,
                     out_tdata[31:0], out_tuser, out_tdata[36:32]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

endmodule
